/* src/hsr_pkg.sv */
// ----------------------------------------------------------------------------
// hsr_pkg
// shared constants and types of the heightmap spike removal filter
// ----------------------------------------------------------------------------
package hsr_pkg;

  // defaults of the top level parameters
  localparam int MAX_SIDE_DEF    = 64;
  localparam int HEIGHT_BITS_DEF = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;
  localparam int SIDE_W     = 7;
  localparam int THR_W      = 23;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd16;
  localparam logic [THR_W-1:0]  THR_RESET  = 23'd800;
  localparam int                MIN_SIDE   = 3;

  // result fields
  localparam int IDX_OUT_W = 6;

  // output queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int OUT_CNT_W = 4;

  typedef struct packed {
    logic first;
    logic second;
  } out_push_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] free;
    logic                 empty;
  } out_stat_t;

endpackage

/* src/heightmap_spike_removal_filter.sv */
// ----------------------------------------------------------------------------
// heightmap_spike_removal_filter
// in-place despike pass over a square height grid streamed in raster order
// ----------------------------------------------------------------------------
// The block takes one height sample per cycle while in_ready is high and
// keeps its row state in two synchronous memories: a two-bank line store
// with the original samples of the current and previous rows, and a store
// with the filtered samples of the row before. An accepted beat reads both
// stores at once, a precompute stage forms the sums that do not depend on
// the left neighbor, and a second stage closes the loop through the just
// filtered left neighbor and picks the first of the three means that is
// farther than the threshold. Results reach the output queue from the
// second stage. Inner rows give one result per input beat, so the block
// runs at one beat per cycle while the output side keeps up; during the last
// row each input beat gives two results and the input is paced by the output
// side, one result per cycle. The stores need no clearing pass after reset.
module heightmap_spike_removal_filter
  import hsr_pkg::*;
#(
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [HEIGHT_BITS-1:0] in_height,
  input  logic                          in_grid_start,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [HEIGHT_BITS-1:0] out_filtered_height,
  output logic [IDX_OUT_W-1:0]          out_row_index,
  output logic [IDX_OUT_W-1:0]          out_col_index,
  output logic                          out_grid_last
);

  localparam int HB    = HEIGHT_BITS;
  localparam int IDX_W = $clog2(MAX_SIDE);
  localparam int NW    = $clog2(MAX_SIDE + 1);
  localparam int PW    = NW + 1;
  localparam int SW    = (NW > SIDE_W) ? NW : SIDE_W;
  localparam int CW    = ((HB + 1 > THR_W) ? HB + 1 : THR_W) + 1;
  localparam int OW    = HB + 2 * IDX_OUT_W + 1;

  // absolute difference of mean and center above the threshold
  function automatic logic exceeds(input logic [HB-1:0] mean,
                                   input logic [HB-1:0] center,
                                   input logic [THR_W-1:0] thr);
    logic [HB:0] d;
    logic [HB:0] mag;
    d   = {mean[HB-1], mean} - {center[HB-1], center};
    mag = d[HB] ? (~d + 1'b1) : d;
    return CW'(mag) > CW'(thr);
  endfunction

  // row and column to the result field width
  function automatic logic [IDX_OUT_W-1:0] to_out_idx(input logic [IDX_W-1:0] x);
    logic [IDX_W+IDX_OUT_W-1:0] ext;
    ext = {{IDX_OUT_W{1'b0}}, x};
    return ext[IDX_OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [SIDE_W-1:0] side_r;
  logic [THR_W-1:0]  thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      thr_r  <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIDE_LENGTH:     side_r <= cfg_wdata[SIDE_W-1:0];
        REG_SPIKE_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
      endcase
    end
  end

  // side clamped into the supported range
  logic [SW-1:0] side_ext, side_clamp;
  logic [PW-1:0] n_w;

  assign side_ext = SW'(side_r);

  always_comb begin
    side_clamp = side_ext;
    if (side_ext < SW'(MIN_SIDE)) begin
      side_clamp = SW'(MIN_SIDE);
    end else if (side_ext > SW'(MAX_SIDE)) begin
      side_clamp = SW'(MAX_SIDE);
    end
  end

  assign n_w = PW'(side_clamp[NW-1:0]);

  // ---------------------------------------------------------------------
  // position counters, updated on each accepted beat
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic             sel_r, sel_nxt;
  logic [IDX_W-1:0] r_cur, j_cur, pr_cur, j_plus;
  logic             sel_cur;
  logic [PW-1:0]    r_w, j_w, pr_w;
  logic             accept;
  logic             row_end, grid_end;
  logic             em1_cur, em2_cur, last_cur, int_cur;

  assign accept  = in_valid && in_ready;

  // a grid start mark puts the position back to the first sample
  assign r_cur   = in_grid_start ? '0 : row_r;
  assign j_cur   = in_grid_start ? '0 : col_r;
  assign sel_cur = in_grid_start ? 1'b0 : sel_r;
  assign pr_cur  = r_cur - 1'b1;
  assign j_plus  = j_cur + 1'b1;

  assign r_w  = PW'(r_cur);
  assign j_w  = PW'(j_cur);
  assign pr_w = PW'(pr_cur);

  assign row_end  = (j_w + 1'b1) >= n_w;
  assign grid_end = (r_w + 1'b1) >= n_w;

  // first result: sample one row up; second result: last row passes through
  assign em1_cur  = (r_cur != '0);
  assign em2_cur  = (r_w == n_w - 1'b1);
  assign last_cur = (j_w == n_w - 1'b1);
  assign int_cur  = em1_cur && (pr_w >= PW'(1)) && (pr_w + PW'(2) <= n_w) &&
                    (j_w >= PW'(1)) && (j_w + PW'(2) <= n_w);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    sel_nxt = sel_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        if (grid_end) begin
          row_nxt = '0;
          sel_nxt = 1'b0;
        end else begin
          row_nxt = r_cur + 1'b1;
          sel_nxt = ~sel_cur;
        end
      end else begin
        row_nxt = r_cur;
        col_nxt = j_plus;
        sel_nxt = sel_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      sel_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      sel_r <= sel_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stores: arriving row goes to bank sel, previous row is read from ~sel
  // ---------------------------------------------------------------------
  logic [HB-1:0]    ctr_q, up_q, left_q;
  logic             upd_we;
  logic [IDX_W-1:0] upd_waddr;
  logic [HB-1:0]    upd_wdata;

  hsr_line_store #(
    .AW (IDX_W + 1),
    .W  (HB)
  ) u_line_store (
    .clk      (clk),
    .wr_en    (accept),
    .wr_addr  ({sel_cur, j_cur}),
    .wr_data  (in_height),
    .rd_addr0 ({~sel_cur, j_cur}),
    .rd_addr1 ({~sel_cur, j_plus}),
    .rd_data0 (ctr_q),
    .rd_data1 (up_q)
  );

  hsr_upd_store #(
    .AW (IDX_W),
    .W  (HB)
  ) u_upd_store (
    .clk     (clk),
    .wr_en   (upd_we),
    .wr_addr (upd_waddr),
    .wr_data (upd_wdata),
    .rd_addr (j_cur),
    .rd_data (left_q)
  );

  // ---------------------------------------------------------------------
  // stage a: store data arrives, sums without the left neighbor
  // ---------------------------------------------------------------------
  logic             va_r;
  logic [HB-1:0]    ha_r;
  logic [IDX_W-1:0] ra_r, pra_r, ja_r;
  logic             em1_a_r, em2_a_r, last_a_r, int_a_r;
  logic [HB:0]      lr_a;
  logic [HB+1:0]    s3_a;
  logic [HB-1:0]    mo_a;
  logic             ex_mo_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ha_r     <= in_height;
    ra_r     <= r_cur;
    pra_r    <= pr_cur;
    ja_r     <= j_cur;
    em1_a_r  <= em1_cur;
    em2_a_r  <= em2_cur;
    last_a_r <= last_cur;
    int_a_r  <= int_cur;
  end

  // outer-axis mean needs only the row above and the arriving sample
  assign lr_a    = {left_q[HB-1], left_q} + {ha_r[HB-1], ha_r};
  assign mo_a    = lr_a[HB:1];
  assign s3_a    = {{2{up_q[HB-1]}}, up_q} + {lr_a[HB], lr_a};
  assign ex_mo_a = exceeds(mo_a, ctr_q, thr_r);

  // ---------------------------------------------------------------------
  // stage b: loop through the left neighbor, three ordered tests
  // ---------------------------------------------------------------------
  logic             vb_r;
  logic [HB-1:0]    hb_r, ctr_b_r, up_b_r, mo_b_r;
  logic [HB+1:0]    s3_b_r;
  logic [IDX_W-1:0] rb_r, prb_r, jb_r;
  logic             em1_b_r, em2_b_r, last_b_r, int_b_r, ex_mo_b_r;
  logic [HB-1:0]    down_r;
  logic [HB+1:0]    s4_b;
  logic [HB:0]      ud_b;
  logic [HB-1:0]    m4_b, mi_b, res_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    hb_r      <= ha_r;
    ctr_b_r   <= ctr_q;
    up_b_r    <= up_q;
    mo_b_r    <= mo_a;
    s3_b_r    <= s3_a;
    ex_mo_b_r <= ex_mo_a;
    rb_r      <= ra_r;
    prb_r     <= pra_r;
    jb_r      <= ja_r;
    em1_b_r   <= em1_a_r;
    em2_b_r   <= em2_a_r;
    last_b_r  <= last_a_r;
    int_b_r   <= int_a_r;
  end

  // means floor by dropping low bits of the sums
  assign s4_b = s3_b_r + {{2{down_r[HB-1]}}, down_r};
  assign m4_b = s4_b[HB+1:2];
  assign ud_b = {up_b_r[HB-1], up_b_r} + {down_r[HB-1], down_r};
  assign mi_b = ud_b[HB:1];

  always_comb begin
    res_b = ctr_b_r;
    priority if (!int_b_r) begin
      res_b = ctr_b_r;
    end else if (exceeds(m4_b, ctr_b_r, thr_r)) begin
      res_b = m4_b;
    end else if (exceeds(mi_b, ctr_b_r, thr_r)) begin
      res_b = mi_b;
    end else if (ex_mo_b_r) begin
      res_b = mo_b_r;
    end else begin
      res_b = ctr_b_r;
    end
  end

  // filtered value feeds the next sample and the next row
  assign upd_we    = vb_r && em1_b_r;
  assign upd_waddr = jb_r;
  assign upd_wdata = res_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r <= '0;
    end else if (vb_r && em1_b_r) begin
      down_r <= res_b;
    end
  end

  // ---------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------
  out_push_t            push;
  out_stat_t            fifo_stat;
  logic [OW-1:0]        beat0, beat1, out_beat;
  logic [OUT_CNT_W-1:0] need;

  assign push.first  = vb_r && em1_b_r;
  assign push.second = vb_r && em2_b_r;

  assign beat0 = {res_b, to_out_idx(prb_r), to_out_idx(jb_r), 1'b0};
  assign beat1 = {hb_r, to_out_idx(rb_r), to_out_idx(jb_r), last_b_r};

  // room for two beats for each item in flight and for the next one
  assign need     = (OUT_CNT_W'(va_r) + OUT_CNT_W'(vb_r) + OUT_CNT_W'(1'b1)) << 1;
  assign in_ready = (fifo_stat.free >= need);

  hsr_out_fifo #(
    .W (OW)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data0 (beat0),
    .push_data1 (beat1),
    .stat       (fifo_stat),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_beat)
  );

  assign out_filtered_height = out_beat[OW-1:2*IDX_OUT_W+1];
  assign out_row_index       = out_beat[2*IDX_OUT_W:IDX_OUT_W+1];
  assign out_col_index       = out_beat[IDX_OUT_W:1];
  assign out_grid_last       = out_beat[0];

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_pass_through_after_first : assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("last-row beat pushed without the beat of the row above");

  a_interior_emits : assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && int_b_r) |-> em1_b_r)
    else $error("interior sample filtered without being emitted");

  a_accept_enters_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (va_r ##1 vb_r))
    else $error("accepted beat lost in the pipeline");

  a_stall_has_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (va_r || vb_r || !fifo_stat.empty))
    else $error("input stalled with empty pipeline and queue");

endmodule

/* src/hsr_line_store.sv */
// ----------------------------------------------------------------------------
// hsr_line_store
// two-bank store of original row samples, one write and two read ports
// ----------------------------------------------------------------------------
module hsr_line_store #(
  parameter int AW = 7,
  parameter int W  = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [W-1:0]  rd_data0,
  output logic [W-1:0]  rd_data1
);

  localparam int DEPTH = 2 ** AW;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

/* src/hsr_upd_store.sv */
// ----------------------------------------------------------------------------
// hsr_upd_store
// store of filtered samples of the previous emitted row
// ----------------------------------------------------------------------------
module hsr_upd_store #(
  parameter int AW = 6,
  parameter int W  = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  localparam int DEPTH = 2 ** AW;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/hsr_out_fifo.sv */
// ----------------------------------------------------------------------------
// hsr_out_fifo
// result queue, takes up to two beats per cycle and hands out one
// ----------------------------------------------------------------------------
module hsr_out_fifo
  import hsr_pkg::*;
#(
  parameter int W = 37
) (
  input  logic      clk,
  input  logic      rst_n,
  input  out_push_t push,
  input  logic [W-1:0] push_data0,
  input  logic [W-1:0] push_data1,
  output out_stat_t stat,
  output logic      pop_valid,
  input  logic      pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]         mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OUT_PTR_W-1:0] wr_ptr_2nd;
  logic                 pop;
  logic [OUT_CNT_W-1:0] n_push;

  assign pop        = pop_valid && pop_ready;
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign n_push     = OUT_CNT_W'(push.first) + OUT_CNT_W'(push.second);
  // second beat lands behind the first one if that one is present
  assign wr_ptr_2nd = wr_ptr_r + OUT_PTR_W'(push.first);

  assign stat.free  = OUT_CNT_W'(OUT_DEPTH) - cnt_r;
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[OUT_PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
    cnt_nxt    = cnt_r + n_push - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr_r] <= push_data0;
    end
    if (push.second) begin
      mem[wr_ptr_2nd] <= push_data1;
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the heightmap spike removal filter
// ----------------------------------------------------------------------------
// A directed burst of three 3x3 grids runs first. It hits the height
// extremes, each of the three mean tests, a back-to-back grid with no start
// mark and a restart in the middle of a grid. After it come nine randomized
// phases, each with its own side length and threshold, including sides that
// clamp to the minimum and the maximum. A phase may also shrink the side in
// the middle of a grid. The random grids are smooth terrain, stripes along
// either axis and spikes near and far past the threshold. An in-bench model
// of the in-place despike pass predicts every result beat, and a monitor
// checks the beats field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import hsr_pkg::*;

  localparam logic signed [23:0] HMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] HMIN = 24'sh800000;
  localparam int DIR_ROWS = 26;
  localparam int PHASES   = 9;

  // one emitted sample as the result channel carries it
  typedef struct packed {
    logic signed [23:0] height;
    logic [5:0]         row;
    logic [5:0]         col;
    logic               last;
  } sample_t;

  // directed row: input beat plus, where typed, the heights that the beat emits
  typedef struct packed {
    logic signed [23:0] height;
    logic               start;
    logic               typed;
    logic signed [23:0] mid_h;
    logic signed [23:0] own_h;
  } dir_row_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;
  typedef enum int {ACT_NONE, ACT_PAUSE, ACT_HOLD} extra_e;

  typedef struct {
    logic [6:0]  side;
    logic [22:0] thr;
    int          items;
    idle_e       mode;
    extra_e      act;
  } phase_t;

  // dut inputs, all known from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SIDE_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [23:0]  in_height = '0;
  logic                in_grid_start = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [23:0]  out_filtered_height;
  logic [5:0]          out_row_index;
  logic [5:0]          out_col_index;
  logic                out_grid_last;

  // filter model state, mirrors the block's line stores and counters
  logic [6:0]         side_reg = SIDE_RESET;
  logic [22:0]        thr_reg  = THR_RESET;
  logic signed [23:0] filtered_row [64];
  logic signed [23:0] raw_row_a [64];
  logic signed [23:0] raw_row_b [64];
  logic signed [23:0] left_filtered = '0;
  int                 row_ctr = 0;
  int                 col_ctr = 0;
  logic               bank_sel = 1'b0;

  sample_t  pending_samples [$];
  dir_row_t directed_tab [DIR_ROWS];
  phase_t   plan [PHASES];

  int errors = 0;
  int beats_in = 0;
  int results_checked = 0;
  int grid_starts = 0;
  int test_hits [3] = '{0, 0, 0};
  int send_pct = 0;
  int recv_pct = 0;
  int stall_left = 0;
  bit hold_req = 1'b0;

  heightmap_spike_removal_filter u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_height           (in_height),
    .in_grid_start       (in_grid_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_height (out_filtered_height),
    .out_row_index       (out_row_index),
    .out_col_index       (out_col_index),
    .out_grid_last       (out_grid_last)
  );

  always #5 clk = ~clk;

  // side register below 3 or above 64 is clamped
  function automatic int clamp_side(logic [6:0] s);
    if (s < MIN_SIDE) return MIN_SIDE;
    if (s > 64) return 64;
    return int'(s);
  endfunction

  // strictly farther than the threshold
  function automatic bit over_limit(logic signed [25:0] mean, logic signed [23:0] c);
    logic signed [25:0] d;
    logic signed [25:0] lim;
    d = mean - 26'(c);
    if (d < 0) d = -d;
    lim = {3'b000, thr_reg};
    return d > lim;
  endfunction

  // one arriving sample: emits the sample above it, and in the last row itself
  task automatic filter_sample(input logic signed [23:0] h, input logic start,
                               output int cnt, output sample_t res [2]);
    int n, r, j;
    logic signed [23:0] center, out_h;
    logic signed [25:0] w_up, w_dn, w_lf, w_rt, m4, mi, mo;
    n = clamp_side(side_reg);
    cnt = 0;
    if (start) begin
      row_ctr = 0;
      col_ctr = 0;
      bank_sel = 1'b0;
      grid_starts++;
    end
    r = row_ctr;
    j = col_ctr;
    if (r >= 1) begin
      // previous row sits in the bank not being filled
      center = bank_sel ? raw_row_a[j] : raw_row_b[j];
      out_h = center;
      if (r >= 2 && r + 1 <= n && j >= 1 && j + 2 <= n) begin
        w_up = bank_sel ? raw_row_a[j + 1] : raw_row_b[j + 1];
        w_dn = left_filtered;
        w_lf = filtered_row[j];
        w_rt = h;
        m4 = (w_up + w_dn + w_lf + w_rt) >>> 2;
        mi = (w_up + w_dn) >>> 1;
        mo = (w_lf + w_rt) >>> 1;
        if (over_limit(m4, center)) begin
          out_h = m4[23:0];
          test_hits[0]++;
        end else if (over_limit(mi, center)) begin
          out_h = mi[23:0];
          test_hits[1]++;
        end else if (over_limit(mo, center)) begin
          out_h = mo[23:0];
          test_hits[2]++;
        end
      end
      filtered_row[j] = out_h;
      left_filtered = out_h;
      res[cnt] = '{out_h, 6'(r - 1), 6'(j), 1'b0};
      cnt++;
    end
    if (bank_sel) raw_row_b[j] = h;
    else raw_row_a[j] = h;
    if (r == n - 1) begin
      res[cnt] = '{h, 6'(r), 6'(j), j == n - 1};
      cnt++;
    end
    if (j + 1 >= n) begin
      col_ctr = 0;
      bank_sel = ~bank_sel;
      if (r + 1 >= n) begin
        row_ctr = 0;
        bank_sel = 1'b0;
      end else begin
        row_ctr = r + 1;
      end
    end else begin
      col_ctr = j + 1;
    end
  endtask

  // both registers back to back; junk above the 7 side bits must be ignored
  task automatic set_filter(input logic [6:0] side, input logic [22:0] thr);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIDE_LENGTH;
    cfg_wdata <= {junk, side};
    @(posedge clk);
    cfg_index <= REG_SPIKE_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_reg = side;
    thr_reg  = thr;
  endtask

  // offer one beat, hold it until taken, then predict what it emits
  task automatic drive_beat(input logic signed [23:0] h, input logic start,
                            input bit typed, input logic signed [23:0] mid_h,
                            input logic signed [23:0] own_h, input bit drain);
    int gap;
    int cnt;
    sample_t res [2];
    gap = 0;
    while (send_pct > 0 && gap < 40 && $urandom_range(0, 99) < send_pct) gap++;
    if (drain || gap > 0) begin
      in_valid <= 1'b0;
      if (drain) begin
        do @(posedge clk); while (pending_samples.size() != 0);
      end
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_height     <= h;
    in_grid_start <= start;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    filter_sample(h, start, cnt, res);
    // hand-computed values for the interior sample of a directed 3x3 grid
    if (typed) begin
      res[0] = '{mid_h, 6'd1, 6'd1, 1'b0};
      res[1] = '{own_h, 6'd2, 6'd1, 1'b0};
    end
    for (int k = 0; k < cnt; k++) pending_samples = {pending_samples, res[k]};
  endtask

  // drop valid, let every pending sample out, then allow for beats in flight
  // that emit nothing (row 0)
  task automatic finish_burst();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_req) begin
      stall_left = 400;
      hold_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // result checker: in-order compare against the predicted samples
  always @(posedge clk) begin
    sample_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_filtered_height, out_row_index, out_col_index, out_grid_last};
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: h=%0d r=%0d c=%0d last=%0d",
                 $time, got.height, got.row, got.col, got.last);
      end else begin
        want = pending_samples.pop_front();
        results_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: expected h=%0d r=%0d c=%0d last=%0d, got h=%0d r=%0d c=%0d last=%0d",
                   $time, want.height, want.row, want.col, want.last,
                   got.height, got.row, got.col, got.last);
        end
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("heightmap_spike_removal_filter: mismatch");
    $finish;
  end

  initial begin : main
    int old_n, pos_r, pos_c, v, base, off, nz, thr_i, pattern;
    bit force_start;
    logic start;

    // grid a: max spike between min inner and max outer neighbors, 4-mean wins
    // grid b: no start mark, inner-axis stripes, 2-mean along the row wins
    // grid d: restarts in the middle of b, outer-axis mean wins, 4-mean on the
    //         threshold itself must not fire
    directed_tab = '{
      '{24'sd0,     1'b1, 1'b0, 24'sd0,     24'sd0},
      '{HMAX,       1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd0,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{HMIN,       1'b0, 1'b0, 24'sd0,     24'sd0},
      '{HMAX,       1'b0, 1'b0, 24'sd0,     24'sd0},
      '{HMIN,       1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd0,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{HMAX,       1'b0, 1'b1, -24'sd1,    HMAX},
      '{24'sd0,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd5,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{-24'sd2000, 1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd7,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd2000,  1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd0,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd2000,  1'b0, 1'b0, 24'sd0,     24'sd0},
      '{-24'sd3,    1'b0, 1'b0, 24'sd0,     24'sd0},
      '{-24'sd2000, 1'b0, 1'b1, 24'sd2000,  -24'sd2000},
      '{24'sd1,     1'b1, 1'b0, 24'sd0,     24'sd0},
      '{24'sd1600,  1'b0, 1'b0, 24'sd0,     24'sd0},
      '{-24'sd1,    1'b0, 1'b0, 24'sd0,     24'sd0},
      '{-24'sd1000, 1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd0,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd1000,  1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd9,     1'b0, 1'b0, 24'sd0,     24'sd0},
      '{24'sd1600,  1'b0, 1'b1, 24'sd1600,  24'sd1600},
      '{-24'sd7,    1'b0, 1'b0, 24'sd0,     24'sd0}
    };

    // side values 0, 1, 65 and 127 exercise the clamp; 4 after 127 shrinks
    // the side in the middle of a grid
    plan = '{
      '{7'd16,  23'd800,     280, IDLE_NONE, ACT_NONE},
      '{7'd0,   23'd0,       120, IDLE_SEND, ACT_PAUSE},
      '{7'd6,   23'd8388607, 150, IDLE_RECV, ACT_NONE},
      '{7'd127, 23'd300,     200, IDLE_BOTH, ACT_NONE},
      '{7'd4,   23'd50,      150, IDLE_NONE, ACT_HOLD},
      '{7'd1,   23'd1,       150, IDLE_BOTH, ACT_NONE},
      '{7'd8,   23'd2000,    200, IDLE_SEND, ACT_NONE},
      '{7'd65,  23'd100000,  150, IDLE_RECV, ACT_NONE},
      '{7'd5,   23'd2,       150, IDLE_BOTH, ACT_NONE}
    };

    base = 0;
    off = 0;
    pattern = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_filter(7'd3, 23'd800);
    foreach (directed_tab[k])
      drive_beat(directed_tab[k].height, directed_tab[k].start, directed_tab[k].typed,
                 directed_tab[k].mid_h, directed_tab[k].own_h, 1'b0);
    finish_burst();

    for (int p = 0; p < PHASES; p++) begin
      old_n = clamp_side(side_reg);
      set_filter(plan[p].side, plan[p].thr);
      send_pct = (plan[p].mode == IDLE_SEND) ? 49 : (plan[p].mode == IDLE_BOTH) ? 34 : 0;
      recv_pct = (plan[p].mode == IDLE_RECV) ? 49 : (plan[p].mode == IDLE_BOTH) ? 34 : 0;
      // growing the side past row 0 would read line store entries that were
      // never written, so such a phase opens a fresh grid
      force_start = (clamp_side(side_reg) > old_n) && (row_ctr >= 1);
      if (plan[p].act == ACT_HOLD) hold_req = 1'b1;
      thr_i = int'(thr_reg);
      nz = thr_i / 8 + 2;

      for (int k = 0; k < plan[p].items; k++) begin
        if (force_start)
          start = 1'b1;
        else if (row_ctr == 0 && col_ctr == 0)
          start = ($urandom_range(0, 9) != 0);
        else
          start = ($urandom_range(0, 249) == 0);   // stray restart mid-grid
        force_start = 1'b0;
        pos_r = start ? 0 : row_ctr;
        pos_c = start ? 0 : col_ctr;

        // new grid: fresh terrain level and stripe pattern
        if (pos_r == 0 && pos_c == 0) begin
          base = int'($urandom_range(0, 8000000)) - 4000000;
          pattern = $urandom_range(0, 2);
          off = thr_i + 1 + int'($urandom_range(0, thr_i));
        end

        case ($urandom_range(0, 19))
          0: v = int'($urandom);
          1: v = $urandom_range(0, 1) ? 8388607 : -8388608;
          2: v = base + ($urandom_range(0, 1) ? 1 : -1) *
                 (2 * thr_i + 1 + int'($urandom_range(0, thr_i)));
          3: v = base + ($urandom_range(0, 1) ? 1 : -1) *
                 (thr_i + int'($urandom_range(0, 2)));
          default: begin
            v = base + int'($urandom_range(0, 2 * nz)) - nz;
            if ((pattern == 1 && pos_c % 2 == 0) || (pattern == 2 && pos_r % 2 == 0))
              v = v + off;
          end
        endcase
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;

        drive_beat(24'(v), start, 1'b0, 24'sd0, 24'sd0,
                   plan[p].act == ACT_PAUSE && k == plan[p].items / 2);
      end
      finish_burst();
    end
    repeat (16) @(posedge clk);

    $display("run: %0d beats in, %0d results checked, %0d grid starts, 9 settings",
             beats_in, results_checked, grid_starts);
    $display("replacements by 4-mean %0d, inner mean %0d, outer mean %0d",
             test_hits[0], test_hits[1], test_hits[2]);
    if (errors == 0) begin
      $display("heightmap_spike_removal_filter: match");
    end else begin
      $display("heightmap_spike_removal_filter: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
src/hsr_pkg.sv
src/hsr_line_store.sv
src/hsr_upd_store.sv
src/hsr_out_fifo.sv
src/heightmap_spike_removal_filter.sv
dv/testbench.sv
